FILE: hw/rtl/pscl_pkg.sv
// Shared types and constants for the per-source connection limiter.
// No dependencies; every file that uses it refers to it by scoped names.
`default_nettype none

package pscl_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int TIME_W  = 48;
	localparam int ADDR_W  = 32;
	localparam int CONN_W  = 16;
	localparam int FAIL_W  = 8;
	localparam int TICKS_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// commands
	localparam logic [1:0] CMD_CHECK     = 2'd0;
	localparam logic [1:0] CMD_CONNECT   = 2'd1;
	localparam logic [1:0] CMD_AUTH_FAIL = 2'd2;
	localparam logic [1:0] CMD_TICK      = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_CONN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_FAIL  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BAN_TICKS = 3'd4;

	// limits seen by every cell
	typedef struct packed {
		logic [CONN_W-1:0]  max_connections;
		logic [FAIL_W-1:0]  auth_fail_limit;
		logic [TICKS_W-1:0] window_ticks;
	} limits_t;

	// request token walking down the cell chain
	typedef struct packed {
		logic              active;
		logic              done;
		logic [1:0]        command;
		logic [ADDR_W-1:0] addr;
		logic              allowed;
		logic              banned;
	} token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pscl_if.sv
// Channel interfaces of the limiter: request, response and register write.
// Uses pscl_pkg for field widths.
`default_nettype none

interface pscl_in_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       command;
	logic [pscl_pkg::ADDR_W-1:0]      source_address;
	modport source(output valid, command, source_address, input ready);
	modport sink(input valid, command, source_address, output ready);
endinterface

interface pscl_out_if;
	logic valid;
	logic ready;
	logic allowed;
	logic banned;
	logic table_full;
	modport source(output valid, allowed, banned, table_full, input ready);
	modport sink(input valid, allowed, banned, table_full, output ready);
endinterface

interface pscl_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pscl_pkg::REG_IDX_W-1:0]     index;
	logic [pscl_pkg::TICKS_W-1:0]       data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pscl_cell.sv
// One table entry of the limiter: stores a source record and acts on the
// request token passing through it. Depends on pscl_pkg.
`default_nettype none

module pscl_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pscl_pkg::limits_t             limits,
	input  wire logic [pscl_pkg::TIME_W-1:0]   now,
	input  wire logic [pscl_pkg::TIME_W-1:0]   ban_end_new,
	input  wire pscl_pkg::token_t              tin,
	output pscl_pkg::token_t                   tout
);

	logic                            valid_q;
	logic [pscl_pkg::ADDR_W-1:0]     addr_q;
	logic [pscl_pkg::CONN_W-1:0]     conn_q;
	logic [pscl_pkg::FAIL_W-1:0]     fail_q;
	logic [pscl_pkg::TIME_W-1:0]     win_start_q;
	logic [pscl_pkg::TIME_W-1:0]     ban_end_q;
	pscl_pkg::token_t                tout_q;
	pscl_pkg::token_t                tok_d;

	logic live, hit, claim, is_check, is_conn, is_fail;
	logic in_ban, expired, fail_ban, under_limit;
	logic [pscl_pkg::TIME_W-1:0] age;
	logic [pscl_pkg::CONN_W-1:0] conn_inc;
	logic [pscl_pkg::FAIL_W-1:0] fail_inc;

	always_comb begin
		live     = tin.active && !tin.done;
		hit      = live && valid_q && (addr_q == tin.addr);
		// entries fill in order, so the first empty cell is the lowest free one
		claim    = live && !valid_q;
		is_check = (tin.command == pscl_pkg::CMD_CHECK);
		is_conn  = (tin.command == pscl_pkg::CMD_CONNECT);
		is_fail  = (tin.command == pscl_pkg::CMD_AUTH_FAIL);

		age         = now - win_start_q;
		expired     = age > {{(pscl_pkg::TIME_W-pscl_pkg::TICKS_W){1'b0}}, limits.window_ticks};
		in_ban      = now < ban_end_q;
		under_limit = conn_q < limits.max_connections;
		conn_inc    = (conn_q == {pscl_pkg::CONN_W{1'b1}}) ? conn_q
			: conn_q + {{(pscl_pkg::CONN_W-1){1'b0}}, 1'b1};
		fail_inc    = (fail_q == {pscl_pkg::FAIL_W{1'b1}}) ? fail_q
			: fail_q + {{(pscl_pkg::FAIL_W-1){1'b0}}, 1'b1};
		fail_ban    = fail_inc >= limits.auth_fail_limit;

		tok_d         = tin;
		tok_d.done    = tin.done || hit || claim;
		tok_d.allowed = tin.allowed
			|| (hit && is_check && !in_ban && (expired || under_limit))
			|| (claim && is_check);
		tok_d.banned  = tin.banned || (hit && is_check && in_ban);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tout_q  <= '0;
		end else begin
			tout_q <= tok_d;
			if (claim && !is_check) begin
				valid_q <= 1'b1;
			end
		end
	end

	// record payload, no reset
	always_ff @(posedge clk) begin
		if (claim && !is_check) begin
			addr_q      <= tin.addr;
			conn_q      <= is_conn ? {{(pscl_pkg::CONN_W-1){1'b0}}, 1'b1} : '0;
			fail_q      <= is_fail ? {{(pscl_pkg::FAIL_W-1){1'b0}}, 1'b1} : '0;
			win_start_q <= now;
			ban_end_q   <= (is_fail && (limits.auth_fail_limit <=
				{{(pscl_pkg::FAIL_W-1){1'b0}}, 1'b1})) ? ban_end_new : '0;
		end else if (hit) begin
			unique case (tin.command)
				pscl_pkg::CMD_CHECK: begin
					if (!in_ban && expired) begin
						conn_q      <= '0;
						win_start_q <= now;
					end
				end
				pscl_pkg::CMD_CONNECT: begin
					conn_q <= conn_inc;
				end
				pscl_pkg::CMD_AUTH_FAIL: begin
					fail_q <= fail_inc;
					if (fail_ban) begin
						ban_end_q <= ban_end_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign tout = tout_q;

endmodule

`default_nettype wire

FILE: hw/rtl/per_source_connection_limiter_core.sv
// Top level of the per-source connection limiter: registers, time base,
// request control and the chain of pscl_cell entries.
// Depends on pscl_pkg, pscl_if.sv and pscl_cell.
//
//   channel | dir | payload                          | transfer
//   req     | in  | command, source_address          | valid && ready
//   rsp     | out | allowed, banned, table_full      | valid && ready
//   cfg     | in  | index, data                      | valid && ready
//
// A tick, or any request while the limiter is disabled, is answered without
// the table.
// A check or record request walks the cell chain one cell per cycle, and no
// new request is accepted before its token leaves the end of the chain.
// Reset clears all entries' valid bits and the time counter at once.
// A response waiting on rsp does not block the next request; one more
// finished response is held internally before req.ready drops.
`default_nettype none

module per_source_connection_limiter_core #(
	parameter int TABLE_ENTRIES = pscl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pscl_in_if.sink     req,
	pscl_out_if.source  rsp,
	pscl_cfg_if.sink    cfg
);

	// configuration
	logic                            enable_q;
	pscl_pkg::limits_t               limits_q;
	logic [pscl_pkg::TICKS_W-1:0]    ban_ticks_q;

	// time base and registered ban end, precomputed from the time counter
	logic [pscl_pkg::TIME_W-1:0]     now_q;
	logic [pscl_pkg::TIME_W-1:0]     ban_end_q;
	logic [pscl_pkg::TIME_W:0]       ban_sum;

	// request control
	logic                            busy_q;
	pscl_pkg::token_t                tok0_q;
	pscl_pkg::token_t                tok [TABLE_ENTRIES+1];
	pscl_pkg::token_t                tail;

	// finished response waiting for the output register
	logic                            fin_valid_q;
	logic                            fin_allowed_q, fin_banned_q, fin_full_q;

	// output register
	logic                            out_valid_q;
	logic                            out_allowed_q, out_banned_q, out_full_q;

	logic accept, fast, tail_full, move_out;

	assign cfg.ready = 1'b1;
	assign req.ready = !busy_q && !fin_valid_q;
	assign accept    = req.valid && req.ready;
	// ticks and a disabled limiter never touch the table
	assign fast      = (req.command == pscl_pkg::CMD_TICK) || !enable_q;

	assign ban_sum = {1'b0, now_q}
		+ {{(pscl_pkg::TIME_W+1-pscl_pkg::TICKS_W){1'b0}}, ban_ticks_q};

	assign tail      = tok[TABLE_ENTRIES];
	// a record that found neither its source nor a free entry
	assign tail_full = !tail.done && (tail.command != pscl_pkg::CMD_CHECK);
	assign move_out  = fin_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q                  <= 1'b1;
			limits_q.max_connections  <= 16'd10;
			limits_q.auth_fail_limit  <= 8'd5;
			limits_q.window_ticks     <= 32'd60;
			ban_ticks_q               <= 32'd300;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pscl_pkg::REG_ENABLE:    enable_q <= cfg.data[0];
				pscl_pkg::REG_MAX_CONN:  limits_q.max_connections <= cfg.data[15:0];
				pscl_pkg::REG_MAX_FAIL:  limits_q.auth_fail_limit <= cfg.data[7:0];
				pscl_pkg::REG_WINDOW:    limits_q.window_ticks <= cfg.data;
				pscl_pkg::REG_BAN_TICKS: ban_ticks_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (accept && (req.command == pscl_pkg::CMD_TICK)
			&& (now_q != pscl_pkg::TIME_MAX)) begin
			now_q <= now_q + {{(pscl_pkg::TIME_W-1){1'b0}}, 1'b1};
		end
	end

	// saturating ban end, refreshed every cycle; time is steady before a token
	// reaches any cell, but the block does not hold ban_ticks steady likewise
	always_ff @(posedge clk) begin
		ban_end_q <= ban_sum[pscl_pkg::TIME_W] ? pscl_pkg::TIME_MAX
			: ban_sum[pscl_pkg::TIME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			tok0_q      <= '0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// token enters the chain for one cycle per table request
			tok0_q.active <= accept && !fast;
			if (accept && fast) begin
				fin_valid_q <= 1'b1;
			end else if (accept) begin
				busy_q         <= 1'b1;
				tok0_q.done    <= 1'b0;
				tok0_q.command <= req.command;
				tok0_q.addr    <= req.source_address;
				tok0_q.allowed <= 1'b0;
				tok0_q.banned  <= 1'b0;
			end else if (busy_q && tail.active) begin
				busy_q      <= 1'b0;
				fin_valid_q <= 1'b1;
			end else if (move_out) begin
				fin_valid_q <= 1'b0;
			end

			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset
	always_ff @(posedge clk) begin
		if (accept && fast) begin
			fin_allowed_q <= (req.command == pscl_pkg::CMD_CHECK) && !enable_q;
			fin_banned_q  <= 1'b0;
			fin_full_q    <= 1'b0;
		end else if (busy_q && tail.active) begin
			// an unknown source is admitted by a check
			fin_allowed_q <= tail.allowed
				|| (!tail.done && (tail.command == pscl_pkg::CMD_CHECK));
			fin_banned_q  <= tail.banned;
			fin_full_q    <= tail_full;
		end
		if (move_out) begin
			out_allowed_q <= fin_allowed_q;
			out_banned_q  <= fin_banned_q;
			out_full_q    <= fin_full_q;
		end
	end

	assign tok[0] = tok0_q;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		pscl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.limits      (limits_q),
			.now         (now_q),
			.ban_end_new (ban_end_q),
			.tin         (tok[i]),
			.tout        (tok[i+1])
		);
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.allowed    = out_allowed_q;
	assign rsp.banned     = out_banned_q;
	assign rsp.table_full = out_full_q;

endmodule

`default_nettype wire

FILE: hw/rtl/pscl_checker.sv
// Port-level checks of the limiter, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module pscl_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic rsp_allowed,
	input wire logic rsp_banned,
	input wire logic rsp_table_full
);

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one was in flight");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_allowed) && $stable(rsp_banned)
			&& $stable(rsp_table_full))
		else $error("stalled response changed");

	// a banned source is never admitted, and an admitted request never reports full
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_allowed && rsp_banned) && !(rsp_table_full && rsp_allowed))
		else $error("contradictory response flags");

endmodule

bind per_source_connection_limiter_core pscl_checker u_pscl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_allowed    (rsp.allowed),
	.rsp_banned     (rsp.banned),
	.rsp_table_full (rsp.table_full)
);

`default_nettype wire
